[rtl/core/v3au_pkg.sv]
package v3au_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int WIDE_W        = 66;
  localparam int TOL_W         = 31;
  localparam int OP_W          = 4;
  localparam int SQ_LAT        = 33;

  localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_W-1:0] OP_CROSS    = 4'd2;
  localparam logic [OP_W-1:0] OP_SCALE    = 4'd3;
  localparam logic [OP_W-1:0] OP_DOT      = 4'd4;
  localparam logic [OP_W-1:0] OP_LEN      = 4'd5;
  localparam logic [OP_W-1:0] OP_NORM     = 4'd6;
  localparam logic [OP_W-1:0] OP_COL      = 4'd7;
  localparam logic [OP_W-1:0] OP_ORTH     = 4'd8;
  localparam logic [OP_W-1:0] OP_STEP_OUT = 4'd9;
  localparam logic [OP_W-1:0] OP_STEP_IN  = 4'd10;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

  localparam logic signed [WIDE_W-1:0] W_MAX =
    {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] W_MIN =
    {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  // word in flight between the early result and the output
  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [2:0][WORD_W-1:0]       a;
    logic [2:0][WORD_W-1:0]       v;
    logic [WORD_W-1:0]            sc;
    logic                         t;
    logic                         sat;
    logic                         mv;
  } side_t;

  // clip to a signed word; top bit is the clip flag
  function automatic logic [WORD_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic [WORD_W:0] r;
    if (v > W_MAX) r = {1'b1, W_MAX[WORD_W-1:0]};
    else if (v < W_MIN) r = {1'b1, W_MIN[WORD_W-1:0]};
    else r = {1'b0, v[WORD_W-1:0]};
    return r;
  endfunction

  function automatic logic is_small(input logic signed [WIDE_W-1:0] v,
                                    input logic [TOL_W-1:0] tol);
    logic [WIDE_W-1:0] m;
    m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    return m < {{(WIDE_W-TOL_W){1'b0}}, tol};
  endfunction

endpackage

[rtl/core/v3au_lane.sv]
module v3au_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [31:0]                   a_i,
  input  logic signed [31:0]                   a_j,
  input  logic signed [31:0]                   a_k,
  input  logic signed [31:0]                   b_i,
  input  logic signed [31:0]                   b_j,
  input  logic signed [31:0]                   b_k,
  input  logic signed [31:0]                   f,
  output logic signed [63:0]                   pd_q,
  output logic signed [63:0]                   sq_q,
  output logic signed [32:0]                   sum_q,
  output logic signed [32:0]                   diff_q,
  output logic signed [v3au_pkg::WIDE_W-1:0]   cross_q,
  output logic signed [v3au_pkg::WIDE_W-1:0]   scale_q
);
  import v3au_pkg::*;

  localparam logic signed [WIDE_W-1:0] HALF =
    {{(WIDE_W-1){1'b0}}, 1'b1} << (FRAC_BITS-1);

  logic signed [63:0] pc1, pc2, ps;
  logic signed [31:0] ai1, bi1;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      pc1  <= a_j * b_k;
      pc2  <= a_k * b_j;
      pd_q <= a_i * b_i;
      ps   <= a_i * f;
      sq_q <= a_i * a_i;
      ai1  <= a_i;
      bi1  <= b_i;
    end
  end

  // stage 2: sum and difference; rescale cross and scale products, round half up
  always_ff @(posedge clk) begin
    if (en) begin
      sum_q   <= {ai1[31], ai1} + {bi1[31], bi1};
      diff_q  <= {ai1[31], ai1} - {bi1[31], bi1};
      cross_q <= ($signed({{2{pc1[63]}}, pc1}) - $signed({{2{pc2[63]}}, pc2}) + HALF)
                 >>> FRAC_BITS;
      scale_q <= ($signed({{2{ps[63]}}, ps}) + HALF) >>> FRAC_BITS;
    end
  end

endmodule

[rtl/core/v3au_sqrt.sv]
module v3au_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [32:0] root
);
  import v3au_pkg::*;

  logic [63:0] rem_q [32];
  logic [63:0] rt_q  [32];

  // one result bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] rin, rtin, trial;
    if (k == 0) begin : g_first
      assign rin  = rad;
      assign rtin = '0;
    end else begin : g_next
      assign rin  = rem_q[k-1];
      assign rtin = rt_q[k-1];
    end
    assign trial = rtin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem_q[k] <= rin - trial;
          rt_q[k]  <= (rtin >> 1) + BIT;
        end else begin
          rem_q[k] <= rin;
          rt_q[k]  <= rtin >> 1;
        end
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (en) root <= rt_q[31][32:0] + 33'(rem_q[31] > rt_q[31]);
  end

endmodule

[rtl/core/v3au_div.sv]
module v3au_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FRAC_BITS+33:0] num,
  input  logic [32:0]           den,
  output logic [FRAC_BITS:0]    quo
);
  import v3au_pkg::*;

  localparam int NW = FRAC_BITS + 34;

  logic [NW-1:0]      rem_q [FRAC_BITS+1];
  logic [32:0]        den_q [FRAC_BITS+1];
  logic [FRAC_BITS:0] quo_q [FRAC_BITS+1];

  // restoring division, quotient never above 2^FRAC_BITS
  for (genvar s = 0; s <= FRAC_BITS; s++) begin : g_stage
    logic [NW-1:0]      rin, trial;
    logic [32:0]        din;
    logic [FRAC_BITS:0] qin;
    if (s == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign din = den_q[s-1];
      assign qin = quo_q[s-1];
    end
    assign trial = NW'(din) << (FRAC_BITS - s);
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[s] <= din;
        if (rin >= trial) begin
          rem_q[s] <= rin - trial;
          quo_q[s] <= {qin[FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_q[s] <= rin;
          quo_q[s] <= {qin[FRAC_BITS-1:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[FRAC_BITS];

endmodule

[rtl/core/vector3_arithmetic_unit.sv]
// Channel | Dir | Signals                    | Word
// s       | in  | s_tvalid/s_tready          | tdata: first_x,y,z, second_x,y,z, factor; tuser: req_type
// m       | out | m_tvalid/m_tready          | tdata: out_x,y,z, out_scalar; tuser: test_true, saturated
// cfg     | in  | cfg_valid/cfg_ready        | cfg_data: zero_tolerance
//
// One word accepted per cycle while m is not stalled, fully pipelined over three component lanes.
// Every opcode takes the same path: the 32-stage square root
// plus rounding and the FRAC_BITS+1 stage dividers per lane set the depth.
// rst is synchronous: clears valid bits, tolerance returns to 1.
// A stall on m stops the whole pipeline; s_tready drops in the same cycle.
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [223:0]                s_tdata,   // first_x, first_y, first_z, second_x,
                                                 // second_y, second_z, factor
  input  logic [v3au_pkg::OP_W-1:0]   s_tuser,   // req_type
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [127:0]                m_tdata,   // out_x, out_y, out_z, out_scalar
  output logic [1:0]                  m_tuser,   // test_true, saturated
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [v3au_pkg::TOL_W-1:0]  cfg_data   // zero_tolerance
);
  import v3au_pkg::*;

  localparam int DIV_LAT = FRAC_BITS + 1;
  localparam int NS      = SQ_LAT + DIV_LAT;
  localparam int NW      = FRAC_BITS + 34;
  localparam logic signed [WIDE_W-1:0] HALF =
    {{(WIDE_W-1){1'b0}}, 1'b1} << (FRAC_BITS-1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic adv;
  logic [TOL_W-1:0] tol;

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // pipeline moves when output is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 0: input register
  logic v0, v1, v2;
  logic [OP_W-1:0] op0, op1, op2;
  logic [2:0][WORD_W-1:0] a0, b0, a1, a2;
  logic [WORD_W-1:0] f0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= s_tuser;
      a0  <= s_tdata[95:0];
      b0  <= s_tdata[191:96];
      f0  <= s_tdata[223:192];
      op1 <= op0;
      a1  <= a0;
      op2 <= op1;
      a2  <= a1;
    end
  end

  // lanes
  logic signed [63:0]        pd [3];
  logic signed [63:0]        sq [3];
  logic signed [32:0]        sum_l [3];
  logic signed [32:0]        diff_l [3];
  logic signed [WIDE_W-1:0]  cross_l [3];
  logic signed [WIDE_W-1:0]  scale_l [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (adv),
      .a_i     ($signed(a0[i])),
      .a_j     ($signed(a0[J])),
      .a_k     ($signed(a0[K])),
      .b_i     ($signed(b0[i])),
      .b_j     ($signed(b0[J])),
      .b_k     ($signed(b0[K])),
      .f       ($signed(f0)),
      .pd_q    (pd[i]),
      .sq_q    (sq[i]),
      .sum_q   (sum_l[i]),
      .diff_q  (diff_l[i]),
      .cross_q (cross_l[i]),
      .scale_q (scale_l[i])
    );
  end

  // merge: dot product and sum of squares
  logic signed [WIDE_W-1:0] dot2;
  logic [63:0] sumsq2;

  always_ff @(posedge clk) begin
    if (adv) begin
      dot2   <= ($signed({{2{pd[0][63]}}, pd[0]}) + $signed({{2{pd[1][63]}}, pd[1]}) +
                 $signed({{2{pd[2][63]}}, pd[2]}) + HALF) >>> FRAC_BITS;
      sumsq2 <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
    end
  end

  // early result for everything that needs no root
  logic [WORD_W:0] s_add [3], s_sub [3], s_cross [3], s_scale [3];
  logic [WORD_W:0] s_dot;
  side_t early;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    assign s_add[i]   = sat_word(WIDE_W'(sum_l[i]));
    assign s_sub[i]   = sat_word(WIDE_W'(diff_l[i]));
    assign s_cross[i] = sat_word(cross_l[i]);
    assign s_scale[i] = sat_word(scale_l[i]);
  end
  assign s_dot = sat_word(dot2);

  always_comb begin
    early     = '0;
    early.op  = op2;
    early.a   = a2;
    case (op2)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) early.v[i] = s_add[i][WORD_W-1:0];
        early.sat = s_add[0][WORD_W] | s_add[1][WORD_W] | s_add[2][WORD_W];
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) early.v[i] = s_sub[i][WORD_W-1:0];
        early.sat = s_sub[0][WORD_W] | s_sub[1][WORD_W] | s_sub[2][WORD_W];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) early.v[i] = s_cross[i][WORD_W-1:0];
        early.sat = s_cross[0][WORD_W] | s_cross[1][WORD_W] | s_cross[2][WORD_W];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) early.v[i] = s_scale[i][WORD_W-1:0];
        early.sat = s_scale[0][WORD_W] | s_scale[1][WORD_W] | s_scale[2][WORD_W];
      end
      OP_DOT: begin
        early.sc  = s_dot[WORD_W-1:0];
        early.sat = s_dot[WORD_W];
      end
      OP_COL: begin
        early.t = is_small(cross_l[0], tol) && is_small(cross_l[1], tol) &&
                  is_small(cross_l[2], tol);
      end
      OP_ORTH: begin
        early.t = is_small(dot2, tol);
      end
      default: begin
      end
    endcase
  end

  // square root
  logic [32:0] len;
  v3au_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sumsq2),
    .root (len)
  );

  // sideband pipeline, aligned with root and dividers
  side_t side [NS];
  logic [NS-1:0] vpipe;
  side_t len_upd;
  side_t at_len;
  logic [33:0] len_ext, tol_ext;

  assign at_len  = side[SQ_LAT-1];
  assign len_ext = {1'b0, len};
  assign tol_ext = {3'b0, tol};

  always_comb begin
    len_upd = at_len;
    case (at_len.op)
      OP_LEN: begin
        if (len[32] || len[31]) begin
          len_upd.sc  = W_MAX[WORD_W-1:0];
          len_upd.sat = 1'b1;
        end else begin
          len_upd.sc  = len[WORD_W-1:0];
        end
      end
      OP_NORM: begin
        len_upd.mv = (len != '0) && (len_ext >= tol_ext);
      end
      OP_STEP_OUT, OP_STEP_IN: begin
        len_upd.v  = at_len.a;
        len_upd.mv = (len != '0) && (len_ext > tol_ext);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[NS-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= early;
      for (int k = 1; k < NS; k++) begin
        side[k] <= (k == SQ_LAT) ? len_upd : side[k-1];
      end
    end
  end

  // unit vector dividers, one per lane
  logic [32:0] den;
  logic [FRAC_BITS:0] quo [3];

  assign den = (len == '0) ? 33'd1 : len;

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [WORD_W-1:0] mag;
    logic [NW-1:0] num;
    assign mag = at_len.a[i][WORD_W-1] ? WORD_W'(-at_len.a[i]) : at_len.a[i];
    assign num = (NW'(mag) << FRAC_BITS) + NW'(len >> 1);
    v3au_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num),
      .den (den),
      .quo (quo[i])
    );
  end

  // final merge
  side_t last, fin;
  logic signed [33:0] unit [3];
  logic [WORD_W:0] s_out [3], s_in [3];

  assign last = side[NS-1];

  for (genvar i = 0; i < 3; i++) begin : g_unit
    logic signed [33:0] qx, ax;
    assign qx      = $signed({{(33-FRAC_BITS){1'b0}}, quo[i]});
    assign ax      = $signed({{2{last.a[i][WORD_W-1]}}, last.a[i]});
    assign unit[i] = last.a[i][WORD_W-1] ? -qx : qx;
    assign s_out[i] = sat_word(WIDE_W'(ax + unit[i]));
    assign s_in[i]  = sat_word(WIDE_W'(ax - unit[i]));
  end

  always_comb begin
    fin = last;
    if (last.mv) begin
      case (last.op)
        OP_NORM: begin
          for (int i = 0; i < 3; i++) fin.v[i] = unit[i][WORD_W-1:0];
        end
        OP_STEP_OUT: begin
          for (int i = 0; i < 3; i++) fin.v[i] = s_out[i][WORD_W-1:0];
          fin.sat = s_out[0][WORD_W] | s_out[1][WORD_W] | s_out[2][WORD_W];
        end
        OP_STEP_IN: begin
          for (int i = 0; i < 3; i++) fin.v[i] = s_in[i][WORD_W-1:0];
          fin.sat = s_in[0][WORD_W] | s_in[1][WORD_W] | s_in[2][WORD_W];
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  logic [OP_W-1:0] out_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vpipe[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {fin.sc, fin.v[2], fin.v[1], fin.v[0]};
      m_tuser <= {fin.sat, fin.t};
      out_op  <= fin.op;
    end
  end

  // checks
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    vpipe[NS-1] |-> (quo[0] <= ONE) && (quo[1] <= ONE) && (quo[2] <= ONE))
    else $error("unit quotient above one");

  a_move_ops: assert property (@(posedge clk) disable iff (rst)
    vpipe[SQ_LAT] && side[SQ_LAT].mv |->
      (side[SQ_LAT].op == OP_NORM) || (side[SQ_LAT].op == OP_STEP_OUT) ||
      (side[SQ_LAT].op == OP_STEP_IN))
    else $error("move flag on wrong opcode");

  a_test_ops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (out_op == OP_COL) || (out_op == OP_ORTH))
    else $error("test flag on wrong opcode");

  a_scalar_ops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_op != OP_DOT) && (out_op != OP_LEN) |-> m_tdata[127:96] == '0)
    else $error("scalar set on wrong opcode");

endmodule
